// ===== sv/rafd_pkg.sv =====
// Shared types, constants and the hex digit decoder of the card frame decoder.
package rafd_pkg;

  localparam logic [7:0] START_MARK   = 8'h02;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_NINE   = 8'h39;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_F = 8'h46;
  localparam logic [7:0] ALPHA_OFFSET = 8'd55;

  localparam int unsigned FRAME_LEN = 14;
  localparam int unsigned IDX_W     = 4;

  // Frame positions that matter to the decode.
  localparam logic [IDX_W-1:0] IDX_START    = 4'd0;
  localparam logic [IDX_W-1:0] IDX_LAST_HEX = 4'd12;
  localparam logic [IDX_W-1:0] IDX_LAST_XOR = 4'd10;
  localparam logic [IDX_W-1:0] IDX_FIRST_ID = 4'd4;
  localparam logic [IDX_W-1:0] IDX_END      = IDX_W'(FRAME_LEN - 1);

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_START = 2'd1,
    STATUS_BAD_SUM   = 2'd2
  } status_e;

  typedef struct packed {
    logic        ok;
    logic [3:0]  val;
  } hex_t;

  typedef struct packed {
    logic        fire;
    logic [31:0] card_id;
    status_e     status;
  } result_t;

  // Decode one upper-case ASCII hex digit.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    logic [7:0] diff;
    h    = '0;
    diff = c - ALPHA_OFFSET;
    if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_F) begin
      h.ok  = 1'b1;
      h.val = diff[3:0];
    end
    return h;
  endfunction

endpackage

// ===== sv/rafd_if.sv =====
// Stream interfaces: received bytes in, decoded frame results out.
interface rafd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rafd_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] card_id;
  logic [1:0]  frame_status;

  modport source (output valid, output card_id, output frame_status, input ready);
  modport sink   (input valid, input card_id, input frame_status, output ready);
endinterface

// ===== sv/rafd_frame_acc.sv =====
// Per-frame state: byte position, nibble pairing, checksum and card ID assembly.
module rafd_frame_acc
  import rafd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic [7:0] byte_i,
  output result_t result_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             start_good_q, start_good_d;
  logic [3:0]       high_q, high_d;
  logic [3:0]       low_q, low_d;
  logic [7:0]       xor_q, xor_d;
  logic [31:0]      id_q, id_d;
  logic             match_q, match_d;

  hex_t       hex;
  logic [7:0] pair;
  status_e    status;

  always_comb begin
    hex  = hex_decode(byte_i);
    pair = {high_q, low_q};

    idx_d        = idx_q;
    start_good_d = start_good_q;
    high_d       = high_q;
    low_d        = low_q;
    xor_d        = xor_q;
    id_d         = id_q;
    match_d      = match_q;

    if (step_i) begin
      if (idx_q == IDX_START) begin
        start_good_d = (byte_i == START_MARK);
        xor_d        = '0;
        id_d         = '0;
        match_d      = 1'b0;
        idx_d        = idx_q + 1'b1;
      end else if (idx_q <= IDX_LAST_HEX) begin
        if (idx_q[0]) begin
          if (hex.ok) high_d = hex.val;
        end else begin
          if (hex.ok) low_d = hex.val;
          pair = {high_q, low_d};
          if (idx_q <= IDX_LAST_XOR) begin
            xor_d = xor_q ^ pair;
            if (idx_q >= IDX_FIRST_ID) id_d = {id_q[23:0], pair};
          end else begin
            match_d = (pair == xor_q);
          end
        end
        idx_d = idx_q + 1'b1;
      end else begin
        idx_d = IDX_START;
      end
    end

    // Start check wins over the checksum.
    if (!start_good_q)  status = STATUS_BAD_START;
    else if (!match_q)  status = STATUS_BAD_SUM;
    else                status = STATUS_OK;

    // Flag the end mark position; the caller qualifies it with its step.
    result_o.fire    = (idx_q > IDX_LAST_HEX);
    result_o.status  = status;
    result_o.card_id = (status == STATUS_OK) ? id_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= IDX_START;
      start_good_q <= 1'b0;
      high_q       <= '0;
      low_q        <= '0;
      xor_q        <= '0;
      id_q         <= '0;
      match_q      <= 1'b0;
    end else begin
      idx_q        <= idx_d;
      start_good_q <= start_good_d;
      high_q       <= high_d;
      low_q        <= low_d;
      xor_q        <= xor_d;
      id_q         <= id_d;
      match_q      <= match_d;
    end
  end

endmodule

// ===== sv/rfid_ascii_frame_decoder.sv =====
// Top level of the ASCII hex card frame decoder.
//
// Decodes 14-byte card-reader frames: a start mark (0x02), twelve upper-case
// ASCII hex digits that pair into six bytes, and an end mark that is counted
// but never checked. Frames are counted strictly in groups of 14 bytes with
// no resynchronization. A character that is not a hex digit keeps the last
// digit decoded in the same high or low role, even from an earlier frame.
// On the end mark one result is produced: frame_status 0 (ok) with the card
// ID made of data bytes 1..4 (byte 1 most significant), 1 when the start
// mark was wrong, or 2 when data bytes 0..4 XOR to something other than
// byte 5; card_id reads zero on any failure. One byte is taken per cycle
// at full rate when not stalled: a byte goes through an input register, then
// is decoded into the frame state and, on the end mark, into the result
// register, from which the result is offered. The input side only stalls
// when a new result is due while the previous one is still waiting to be
// taken.
module rfid_ascii_frame_decoder
  import rafd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  rafd_byte_if.sink     rx_i,
  rafd_result_if.source res_o
);

  logic        rx_valid_q;
  logic [7:0]  rx_byte_q;
  logic        res_valid_q, res_valid_d;
  logic [31:0] card_id_q;
  status_e     status_q;

  logic    advance;
  result_t res;

  rafd_frame_acc u_frame_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (rx_byte_q),
    .result_o (res)
  );

  // Hold the registered byte only when it would finish a frame while the
  // result register is still full and not draining.
  assign advance    = rx_valid_q && (!res.fire || !res_valid_q || res_o.ready);
  assign rx_i.ready = !rx_valid_q || advance;

  always_comb begin
    res_valid_d = res_valid_q;
    if (advance && res.fire)       res_valid_d = 1'b1;
    else if (res_o.ready)          res_valid_d = 1'b0;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (rx_i.ready) rx_valid_q <= rx_i.valid;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload: capture a byte on each input transfer, a result on each end mark.
  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) rx_byte_q <= rx_i.rx_byte;
    if (advance && res.fire) begin
      card_id_q <= res.card_id;
      status_q  <= res.status;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.card_id      = card_id_q;
  assign res_o.frame_status = status_q;

endmodule
